@@ src/cndm_pkg.sv @@
// Shared types and constants for the CAN node discovery monitor.
// Depends on nothing; every other file of the block imports it.
package cndm_pkg;

    // Table sizes
    localparam int MAX_NODES       = 16;
    localparam int WHITELIST_DEPTH = 32;

    // Derived widths for table indexes and counts
    localparam int NODE_IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NODE_CNT_W = $clog2(MAX_NODES + 1);
    localparam int WL_IDX_W   = (WHITELIST_DEPTH > 1) ? $clog2(WHITELIST_DEPTH) : 1;
    localparam int WL_CNT_W   = $clog2(WHITELIST_DEPTH + 1);

    // Fixed field widths
    localparam int ID_W    = 32;
    localparam int TICK_W  = 32;
    localparam int COUNT_W = 5;
    localparam int SLOT_W  = 4;
    localparam int IVAL_W  = 16;

    // Byte 1 value that announces the charge limits
    localparam logic [7:0] LIMITS_CODE = 8'd37;

    // APB register map
    localparam int APB_ADDR_W = 5;
    localparam logic [2:0] REG_EXPECTED   = 3'd0;
    localparam logic [2:0] REG_WL_SIZE    = 3'd1;
    localparam logic [2:0] REG_CHARGER_ID = 3'd2;
    localparam logic [2:0] REG_WINDOW     = 3'd3;
    localparam logic [2:0] REG_POLL       = 3'd4;
    localparam logic [2:0] REG_KEEPALIVE  = 3'd5;
    localparam logic [2:0] REG_SILENCE    = 3'd6;

    typedef enum logic [1:0] {
        OP_FRAME    = 2'd0,
        OP_TICK     = 2'd1,
        OP_START    = 2'd2,
        OP_WL_WRITE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DISC     = 2'd1,
        PH_CHARGING = 2'd2,
        PH_FAILED   = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WL_WRITE,
        ST_START,
        ST_FRAME,
        ST_WL_REQ,
        ST_WL_CMP,
        ST_ON_REQ,
        ST_ON_CMP,
        ST_HIT,
        ST_ADD,
        ST_T_INC,
        ST_T_KA,
        ST_T_SIL,
        ST_T_WIN,
        ST_T_POLL,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic [COUNT_W-1:0] expected_modules;
        logic [4:0]         whitelist_size;
        logic [ID_W-1:0]    charger_id;
        logic [IVAL_W-1:0]  discovery_window;
        logic [IVAL_W-1:0]  poll_interval;
        logic [IVAL_W-1:0]  keepalive_interval;
        logic [IVAL_W-1:0]  silence_limit;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic wl_write;
        logic start;
        logic frame;
        logic charger_mark;
        logic wl_read;
        logic wl_next;
        logic on_read;
        logic on_next;
        logic hit;
        logic add;
        logic t_inc;
        logic t_ka;
        logic t_sil;
        logic t_win;
        logic t_poll;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic phase_idle;
        logic phase_disc;
        logic charger_hit;
        logic wl_empty;
        logic wl_match;
        logic wl_last;
        logic on_empty;
        logic on_match;
        logic on_last;
        logic table_full;
        logic tick_disc;
        logic out_free;
    } status_t;

endpackage

@@ src/cndm_if.sv @@
// Valid/ready channel interfaces for the input items and the result items.
// Depends on cndm_pkg for field widths.
interface cndm_item_if
    import cndm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [ID_W-1:0]   frame_id;
    logic [7:0]        payload_byte1;
    logic [4:0]        entry_index;

    modport source (output valid, output opcode, output frame_id, output payload_byte1,
                    output entry_index, input ready);
    modport sink   (input valid, input opcode, input frame_id, input payload_byte1,
                    input entry_index, output ready);
endinterface

interface cndm_result_if
    import cndm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         phase;
    logic [COUNT_W-1:0] nodes_online;
    logic               charger_present;
    logic               new_node;
    logic [SLOT_W-1:0]  node_slot;
    logic               limits_seen;
    logic               send_keepalive;
    logic               send_poll;
    logic               bus_silent;

    modport source (output valid, output phase, output nodes_online, output charger_present,
                    output new_node, output node_slot, output limits_seen,
                    output send_keepalive, output send_poll, output bus_silent,
                    input ready);
    modport sink   (input valid, input phase, input nodes_online, input charger_present,
                    input new_node, input node_slot, input limits_seen,
                    input send_keepalive, input send_poll, input bus_silent,
                    output ready);
endinterface

@@ src/cndm_regs.sv @@
// APB configuration registers of the discovery monitor.
// Depends on cndm_pkg for the register map and the cfg_t bundle.
module cndm_regs
    import cndm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_index;
    logic       wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    // Decode the write transaction
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_index)
                REG_EXPECTED:   cfg_next.expected_modules   = pwdata[COUNT_W-1:0];
                REG_WL_SIZE:    cfg_next.whitelist_size     = pwdata[4:0];
                REG_CHARGER_ID: cfg_next.charger_id         = pwdata;
                REG_WINDOW:     cfg_next.discovery_window   = pwdata[IVAL_W-1:0];
                REG_POLL:       cfg_next.poll_interval      = pwdata[IVAL_W-1:0];
                REG_KEEPALIVE:  cfg_next.keepalive_interval = pwdata[IVAL_W-1:0];
                REG_SILENCE:    cfg_next.silence_limit      = pwdata[IVAL_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the register values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_modules   <= COUNT_W'(6);
            cfg_reg.whitelist_size     <= 5'd0;
            cfg_reg.charger_id         <= 32'hC037_2FA4;
            cfg_reg.discovery_window   <= IVAL_W'(90);
            cfg_reg.poll_interval      <= IVAL_W'(10);
            cfg_reg.keepalive_interval <= IVAL_W'(10);
            cfg_reg.silence_limit      <= IVAL_W'(60);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Return the addressed register
    always_comb
    begin
        case (reg_index)
            REG_EXPECTED:   prdata = 32'(cfg_reg.expected_modules);
            REG_WL_SIZE:    prdata = 32'(cfg_reg.whitelist_size);
            REG_CHARGER_ID: prdata = cfg_reg.charger_id;
            REG_WINDOW:     prdata = 32'(cfg_reg.discovery_window);
            REG_POLL:       prdata = 32'(cfg_reg.poll_interval);
            REG_KEEPALIVE:  prdata = 32'(cfg_reg.keepalive_interval);
            REG_SILENCE:    prdata = 32'(cfg_reg.silence_limit);
            default:        prdata = 32'd0;
        endcase
    end

endmodule

@@ src/cndm_ctrl.sv @@
// Sequencing controller of the discovery monitor: one item at a time.
// Depends on cndm_pkg for the state, command and status types.
module cndm_ctrl
    import cndm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic [1:0] in_opcode,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    op_t         op;

    assign op = op_t'(in_opcode);

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance the sequence and issue commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (op)
                        OP_WL_WRITE: state_next = ST_WL_WRITE;
                        OP_START:    state_next = ST_START;
                        OP_FRAME:    state_next = ST_FRAME;
                        OP_TICK:     state_next = status.phase_idle ? ST_DONE : ST_T_INC;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_WL_WRITE:
            begin
                cmd.wl_write = 1'b1;
                state_next   = ST_DONE;
            end
            ST_START:
            begin
                cmd.start  = 1'b1;
                state_next = ST_DONE;
            end
            ST_FRAME:
            begin
                cmd.frame = 1'b1;
                if (!status.phase_disc)
                begin
                    state_next = ST_DONE;
                end
                else if (status.charger_hit)
                begin
                    cmd.charger_mark = 1'b1;
                    state_next       = ST_DONE;
                end
                else if (status.wl_empty)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_WL_REQ;
                end
            end
            ST_WL_REQ:
            begin
                cmd.wl_read = 1'b1;
                state_next  = ST_WL_CMP;
            end
            ST_WL_CMP:
            begin
                if (status.wl_match)
                begin
                    if (status.table_full)
                        state_next = ST_DONE;
                    else if (status.on_empty)
                        state_next = ST_ADD;
                    else
                        state_next = ST_ON_REQ;
                end
                else if (status.wl_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.wl_next = 1'b1;
                    state_next  = ST_WL_REQ;
                end
            end
            ST_ON_REQ:
            begin
                cmd.on_read = 1'b1;
                state_next  = ST_ON_CMP;
            end
            ST_ON_CMP:
            begin
                if (status.on_match)
                begin
                    state_next = ST_HIT;
                end
                else if (status.on_last)
                begin
                    state_next = ST_ADD;
                end
                else
                begin
                    cmd.on_next = 1'b1;
                    state_next  = ST_ON_REQ;
                end
            end
            ST_HIT:
            begin
                cmd.hit    = 1'b1;
                state_next = ST_DONE;
            end
            ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = ST_DONE;
            end
            ST_T_INC:
            begin
                cmd.t_inc  = 1'b1;
                state_next = ST_T_KA;
            end
            ST_T_KA:
            begin
                cmd.t_ka   = 1'b1;
                state_next = ST_T_SIL;
            end
            ST_T_SIL:
            begin
                cmd.t_sil  = 1'b1;
                state_next = status.tick_disc ? ST_T_WIN : ST_DONE;
            end
            ST_T_WIN:
            begin
                cmd.t_win  = 1'b1;
                state_next = ST_T_POLL;
            end
            ST_T_POLL:
            begin
                cmd.t_poll = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/cndm_dp.sv @@
// Datapath of the discovery monitor: tables, deadlines, tick count, result register.
// Depends on cndm_pkg; driven by commands from cndm_ctrl.
module cndm_dp
    import cndm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic [ID_W-1:0]     in_frame_id,
    input  logic [7:0]          in_payload_byte1,
    input  logic [4:0]          in_entry_index,
    cndm_result_if.source       result_out
);

    // Whitelist and online tables
    logic [ID_W-1:0] wl_mem [WHITELIST_DEPTH];
    logic [ID_W-1:0] on_mem [MAX_NODES];
    logic [ID_W-1:0] wl_rdata_reg;
    logic [ID_W-1:0] on_rdata_reg;

    // Latched item
    logic [ID_W-1:0] id_reg;
    logic [7:0]      byte1_reg;
    logic [4:0]      index_reg;

    // Monitor state
    logic [TICK_W-1:0]     tick_reg, tick_next;
    logic [TICK_W-1:0]     ka_dl_reg, ka_dl_next;
    logic [TICK_W-1:0]     win_dl_reg, win_dl_next;
    logic [TICK_W-1:0]     poll_dl_reg, poll_dl_next;
    logic [TICK_W-1:0]     sil_dl_reg, sil_dl_next;
    phase_t                phase_reg, phase_next;
    logic [NODE_CNT_W-1:0] count_reg, count_next;
    logic                  charger_reg, charger_next;
    logic                  tick_disc_reg, tick_disc_next;

    // Search counters
    logic [WL_CNT_W-1:0]   wl_cnt_reg, wl_cnt_next;
    logic [NODE_CNT_W-1:0] on_cnt_reg, on_cnt_next;

    // Per-item result flags
    logic                  new_node_reg, new_node_next;
    logic [NODE_CNT_W-1:0] slot_reg, slot_next;
    logic                  lim_reg, lim_next;
    logic                  ka_reg, ka_next;
    logic                  poll_reg, poll_next;
    logic                  silent_reg, silent_next;

    // Output register
    logic out_valid_reg, out_valid_next;

    logic [WL_CNT_W-1:0] wl_n;
    logic [TICK_W-1:0]   dl_sel;
    logic [TICK_W-1:0]   dl_diff;
    logic                dl_passed;
    logic                limits_hit;

    // Search bound of the whitelist
    assign wl_n = (32'(cfg.whitelist_size) < WHITELIST_DEPTH) ?
                  WL_CNT_W'(cfg.whitelist_size) : WL_CNT_W'(WHITELIST_DEPTH);

    // Shared serial-number compare against the deadline of this step
    always_comb
    begin
        if (cmd.t_sil)
            dl_sel = sil_dl_reg;
        else if (cmd.t_win)
            dl_sel = win_dl_reg;
        else if (cmd.t_poll)
            dl_sel = poll_dl_reg;
        else
            dl_sel = ka_dl_reg;
    end

    assign dl_diff    = tick_reg - dl_sel;
    assign dl_passed  = (dl_diff != '0) && !dl_diff[TICK_W-1];
    assign limits_hit = (byte1_reg == LIMITS_CODE);

    // Status to the controller
    always_comb
    begin
        status.phase_idle  = (phase_reg == PH_IDLE);
        status.phase_disc  = (phase_reg == PH_DISC);
        status.charger_hit = (id_reg == cfg.charger_id);
        status.wl_empty    = (wl_n == '0);
        status.wl_match    = (wl_rdata_reg == id_reg);
        status.wl_last     = (WL_CNT_W'(wl_cnt_reg + 1'b1) == wl_n);
        status.on_empty    = (count_reg == '0);
        status.on_match    = (on_rdata_reg == id_reg);
        status.on_last     = (NODE_CNT_W'(on_cnt_reg + 1'b1) == count_reg);
        status.table_full  = (32'(count_reg) >= MAX_NODES);
        status.tick_disc   = tick_disc_reg;
        status.out_free    = !out_valid_reg || result_out.ready;
    end

    // Compute next state from the command of this cycle
    always_comb
    begin
        tick_next      = tick_reg;
        ka_dl_next     = ka_dl_reg;
        win_dl_next    = win_dl_reg;
        poll_dl_next   = poll_dl_reg;
        sil_dl_next    = sil_dl_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        charger_next   = charger_reg;
        tick_disc_next = tick_disc_reg;
        wl_cnt_next    = wl_cnt_reg;
        on_cnt_next    = on_cnt_reg;
        new_node_next  = new_node_reg;
        slot_next      = slot_reg;
        lim_next       = lim_reg;
        ka_next        = ka_reg;
        poll_next      = poll_reg;
        silent_next    = silent_reg;
        out_valid_next = out_valid_reg;

        // Drop the result once the receiver takes it
        if (result_out.ready)
            out_valid_next = 1'b0;

        if (cmd.load)
        begin
            new_node_next = 1'b0;
            slot_next     = '0;
            lim_next      = 1'b0;
            ka_next       = 1'b0;
            poll_next     = 1'b0;
            silent_next   = 1'b0;
        end

        // Open a discovery window
        if (cmd.start)
        begin
            count_next   = '0;
            charger_next = 1'b0;
            tick_next    = '0;
            win_dl_next  = TICK_W'(cfg.discovery_window);
            poll_dl_next = TICK_W'(cfg.poll_interval);
            ka_dl_next   = TICK_W'(cfg.keepalive_interval);
            sil_dl_next  = TICK_W'(cfg.silence_limit);
            phase_next   = PH_DISC;
            poll_next    = 1'b1;
        end

        // Any frame restarts the silence deadline
        if (cmd.frame)
        begin
            sil_dl_next = tick_reg + TICK_W'(cfg.silence_limit);
            wl_cnt_next = '0;
            on_cnt_next = '0;
        end

        if (cmd.charger_mark)
            charger_next = 1'b1;

        if (cmd.wl_next)
            wl_cnt_next = WL_CNT_W'(wl_cnt_reg + 1'b1);

        if (cmd.on_next)
            on_cnt_next = NODE_CNT_W'(on_cnt_reg + 1'b1);

        // Known node seen again
        if (cmd.hit)
        begin
            slot_next = on_cnt_reg;
            lim_next  = limits_hit;
        end

        // New node enters the table at the current count
        if (cmd.add)
        begin
            count_next    = NODE_CNT_W'(count_reg + 1'b1);
            new_node_next = 1'b1;
            slot_next     = count_reg;
            if (32'(count_reg) + 1 >= MAX_NODES)
                phase_next = PH_FAILED;
            else
                lim_next = limits_hit;
        end

        // Tick steps
        if (cmd.t_inc)
        begin
            tick_next      = tick_reg + 1'b1;
            tick_disc_next = (phase_reg == PH_DISC);
        end

        if (cmd.t_ka && dl_passed)
        begin
            ka_dl_next = ka_dl_reg + TICK_W'(cfg.keepalive_interval);
            ka_next    = 1'b1;
        end

        if (cmd.t_sil && dl_passed)
        begin
            sil_dl_next = sil_dl_reg + TICK_W'(cfg.silence_limit);
            silent_next = 1'b1;
        end

        if (cmd.t_win && dl_passed)
        begin
            if (charger_reg && (32'(count_reg) == 32'(cfg.expected_modules)))
                phase_next = PH_CHARGING;
            else
                phase_next = PH_FAILED;
        end

        if (cmd.t_poll && dl_passed)
        begin
            poll_dl_next = tick_reg + TICK_W'(cfg.poll_interval);
            poll_next    = 1'b1;
        end

        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    // Hold the control and monitor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            ka_dl_reg     <= '0;
            win_dl_reg    <= '0;
            poll_dl_reg   <= '0;
            sil_dl_reg    <= '0;
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            charger_reg   <= 1'b0;
            tick_disc_reg <= 1'b0;
            wl_cnt_reg    <= '0;
            on_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tick_reg      <= tick_next;
            ka_dl_reg     <= ka_dl_next;
            win_dl_reg    <= win_dl_next;
            poll_dl_reg   <= poll_dl_next;
            sil_dl_reg    <= sil_dl_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            charger_reg   <= charger_next;
            tick_disc_reg <= tick_disc_next;
            wl_cnt_reg    <= wl_cnt_next;
            on_cnt_reg    <= on_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the per-item flags
    always_ff @(posedge clk)
    begin
        new_node_reg <= new_node_next;
        slot_reg     <= slot_next;
        lim_reg      <= lim_next;
        ka_reg       <= ka_next;
        poll_reg     <= poll_next;
        silent_reg   <= silent_next;
    end

    // Latch the accepted transaction
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id_reg    <= in_frame_id;
            byte1_reg <= in_payload_byte1;
            index_reg <= in_entry_index;
        end
    end

    // Whitelist memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wl_write && (32'(index_reg) < WHITELIST_DEPTH))
            wl_mem[WL_IDX_W'(index_reg)] <= id_reg;
        if (cmd.wl_read)
            wl_rdata_reg <= wl_mem[wl_cnt_reg[WL_IDX_W-1:0]];
    end

    // Online table memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.add)
            on_mem[count_reg[NODE_IDX_W-1:0]] <= id_reg;
        if (cmd.on_read)
            on_rdata_reg <= on_mem[on_cnt_reg[NODE_IDX_W-1:0]];
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_out.phase           <= phase_reg;
            result_out.nodes_online    <= COUNT_W'(count_reg);
            result_out.charger_present <= charger_reg;
            result_out.new_node        <= new_node_reg;
            result_out.node_slot       <= SLOT_W'(slot_reg);
            result_out.limits_seen     <= lim_reg;
            result_out.send_keepalive  <= ka_reg;
            result_out.send_poll       <= poll_reg;
            result_out.bus_silent      <= silent_reg;
        end
    end

    assign result_out.valid = out_valid_reg;

endmodule

@@ src/can_node_discovery_monitor.sv @@
// CAN node discovery monitor: top level joining registers, controller and datapath.
// Depends on cndm_pkg, cndm_if, cndm_regs, cndm_ctrl and cndm_dp.
//
// Usage: items arrive on item_in (valid/ready); each gives exactly one result on
// result_out. Opcodes: frame received, tick, start discovery, whitelist write.
// Configuration is written over the APB port (registers at 4*i, pready always high)
// while no item is in flight.
// One item is worked at a time. Whitelist write and start each run one command state;
// a tick in idle goes straight to the result, other ticks step through increment,
// keepalive, silence and, in discovery, window and poll (one shared deadline compare
// per step); a frame searches the whitelist and then the online table one entry at a
// time, each entry through a request and a compare state on its registered read port.
// The result register parts the two sides: a new item is taken while an earlier
// result still waits; a stalled receiver holds only the finish of the next item.
// Reset: phase idle, tick count, deadlines and online count zero, registers at their
// defaults; the tables hold nothing valid and need no clearing pass.
module can_node_discovery_monitor
    import cndm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    cndm_item_if.sink             item_in,
    cndm_result_if.source         result_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    cndm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cndm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_in.valid),
        .in_opcode (item_in.opcode),
        .in_ready  (item_in.ready),
        .status    (status),
        .cmd       (cmd)
    );

    cndm_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .cmd              (cmd),
        .status           (status),
        .in_frame_id      (item_in.frame_id),
        .in_payload_byte1 (item_in.payload_byte1),
        .in_entry_index   (item_in.entry_index),
        .result_out       (result_out)
    );

    // Online count never exceeds the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> (32'(result_out.nodes_online) <= MAX_NODES))
        else $error("nodes_online beyond table size");

    // A node is added only during discovery or by filling the table
    a_new_node_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.new_node) |->
        (result_out.phase == PH_DISC || result_out.phase == PH_FAILED))
        else $error("new node reported outside discovery");

    // Limits are reported only in discovery, so never on the frame that fills the table
    a_limits_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.limits_seen) |-> (result_out.phase == PH_DISC))
        else $error("limits reported outside discovery");

    // An accepted transaction leaves the block busy in the following cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_in.valid && item_in.ready) |=> !item_in.ready)
        else $error("item taken while previous item in flight");

endmodule

@@ tb/sv/can_node_discovery_monitor_tb.sv @@
// Self-checking testbench for can_node_discovery_monitor: random item traffic,
// APB configuration between discovery sessions, and a transaction-level predictor.
// Depends on cndm_pkg, cndm_if and the RTL of the block.
module can_node_discovery_monitor_tb;
    import cndm_pkg::*;

    localparam int RANDOM_ITEMS = 1340;
    localparam int QUIET_TAIL   = 200;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int SETTLE       = 64;

    typedef struct packed {
        phase_t             phase;
        logic [COUNT_W-1:0] nodes_online;
        logic               charger_present;
        logic               new_node;
        logic [SLOT_W-1:0]  node_slot;
        logic               limits_seen;
        logic               send_keepalive;
        logic               send_poll;
        logic               bus_silent;
    } discovery_result_t;

    // Predicts the discovery state and checks every result transaction in order
    class discovery_scoreboard;
        logic [COUNT_W-1:0] expected_cnt;
        logic [4:0]         wl_size;
        logic [ID_W-1:0]    charger_id;
        logic [IVAL_W-1:0]  window_len;
        logic [IVAL_W-1:0]  poll_ival;
        logic [IVAL_W-1:0]  ka_ival;
        logic [IVAL_W-1:0]  silence_ival;

        logic [TICK_W-1:0]  tick_count;
        logic [TICK_W-1:0]  ka_dl;
        logic [TICK_W-1:0]  window_dl;
        logic [TICK_W-1:0]  poll_dl;
        logic [TICK_W-1:0]  silence_dl;
        phase_t             phase;
        logic [COUNT_W-1:0] online_count;
        logic               charger_seen;
        logic [ID_W-1:0]    allowed_ids [WHITELIST_DEPTH];
        logic [ID_W-1:0]    online_ids [MAX_NODES];

        discovery_result_t  expected_results[$];
        int errors;
        int n_checked;
        int n_added;
        int n_full;
        int n_charging;
        int n_failed_close;
        int n_limits;

        function new();
            expected_cnt = 5'd6;
            wl_size      = 5'd0;
            charger_id   = 32'hC037_2FA4;
            window_len   = 16'd90;
            poll_ival    = 16'd10;
            ka_ival      = 16'd10;
            silence_ival = 16'd60;
            tick_count   = '0;
            ka_dl        = '0;
            window_dl    = '0;
            poll_dl      = '0;
            silence_dl   = '0;
            phase        = PH_IDLE;
            online_count = '0;
            charger_seen = 1'b0;
            foreach (allowed_ids[i]) allowed_ids[i] = '0;
            foreach (online_ids[i]) online_ids[i] = '0;
        endfunction

        function void set_reg(logic [2:0] reg_idx, logic [31:0] value);
            case (reg_idx)
                REG_EXPECTED:   expected_cnt = value[COUNT_W-1:0];
                REG_WL_SIZE:    wl_size      = value[4:0];
                REG_CHARGER_ID: charger_id   = value;
                REG_WINDOW:     window_len   = value[IVAL_W-1:0];
                REG_POLL:       poll_ival    = value[IVAL_W-1:0];
                REG_KEEPALIVE:  ka_ival      = value[IVAL_W-1:0];
                REG_SILENCE:    silence_ival = value[IVAL_W-1:0];
                default: ;
            endcase
        endfunction

        // Serial-number compare: deadline counts as passed once strictly behind now
        function bit deadline_passed(logic [TICK_W-1:0] now, logic [TICK_W-1:0] dl);
            logic [TICK_W-1:0] diff;
            diff = now - dl;
            return (diff != '0) && !diff[TICK_W-1];
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Advance the predicted state by one accepted item and queue its result
        function void note_item(op_t op, logic [ID_W-1:0] id, logic [7:0] byte1,
                                logic [4:0] idx);
            discovery_result_t r;
            bit was_disc;
            bit found;
            bit hit;
            int wl_pos;
            int slot;
            r = '0;
            case (op)
                OP_WL_WRITE: allowed_ids[idx] = id;
                OP_START: begin
                    online_count = '0;
                    charger_seen = 1'b0;
                    tick_count   = '0;
                    window_dl    = TICK_W'(window_len);
                    poll_dl      = TICK_W'(poll_ival);
                    ka_dl        = TICK_W'(ka_ival);
                    silence_dl   = TICK_W'(silence_ival);
                    phase        = PH_DISC;
                    r.send_poll  = 1'b1;
                end
                OP_FRAME: begin
                    silence_dl = tick_count + TICK_W'(silence_ival);
                    if (phase == PH_DISC) begin
                        if (id == charger_id) begin
                            charger_seen = 1'b1;
                        end
                        else begin
                            found = 1'b0;
                            for (wl_pos = 0; wl_pos < int'(wl_size); wl_pos++) begin
                                if (allowed_ids[wl_pos] == id) begin
                                    found = 1'b1;
                                    break;
                                end
                            end
                            if (found) begin
                                hit = 1'b0;
                                for (slot = 0; slot < int'(online_count) && slot < MAX_NODES;
                                     slot++) begin
                                    if (online_ids[slot] == id) begin
                                        hit = 1'b1;
                                        break;
                                    end
                                end
                                // Add an unseen node; the last free slot fails the session
                                if (!hit && slot < MAX_NODES) begin
                                    online_ids[slot] = id;
                                    online_count     = online_count + 1'b1;
                                    r.new_node       = 1'b1;
                                    r.node_slot      = SLOT_W'(slot);
                                    n_added++;
                                    if (int'(online_count) >= MAX_NODES) begin
                                        phase = PH_FAILED;
                                        n_full++;
                                    end
                                end
                                else if (hit) begin
                                    r.node_slot = SLOT_W'(slot);
                                end
                                if ((hit || r.new_node) && phase == PH_DISC &&
                                    byte1 == LIMITS_CODE) begin
                                    r.limits_seen = 1'b1;
                                    n_limits++;
                                end
                            end
                        end
                    end
                end
                OP_TICK: begin
                    if (phase != PH_IDLE) begin
                        was_disc   = (phase == PH_DISC);
                        tick_count = tick_count + 1'b1;
                        if (deadline_passed(tick_count, ka_dl)) begin
                            ka_dl            = ka_dl + TICK_W'(ka_ival);
                            r.send_keepalive = 1'b1;
                        end
                        if (deadline_passed(tick_count, silence_dl)) begin
                            silence_dl   = silence_dl + TICK_W'(silence_ival);
                            r.bus_silent = 1'b1;
                        end
                        if (was_disc) begin
                            if (deadline_passed(tick_count, window_dl)) begin
                                if (charger_seen && online_count == expected_cnt) begin
                                    phase = PH_CHARGING;
                                    n_charging++;
                                end
                                else begin
                                    phase = PH_FAILED;
                                    n_failed_close++;
                                end
                            end
                            if (deadline_passed(tick_count, poll_dl)) begin
                                poll_dl     = tick_count + TICK_W'(poll_ival);
                                r.send_poll = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
            r.phase           = phase;
            r.nodes_online    = online_count;
            r.charger_present = charger_seen;
            expected_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH: %s", msg);
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                          n_checked, name, got, want));
        endtask

        task check_result(discovery_result_t got);
            discovery_result_t want;
            if (expected_results.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
                return;
            end
            want = expected_results.pop_front();
            check_field("phase", 32'(got.phase), 32'(want.phase));
            check_field("nodes_online", 32'(got.nodes_online), 32'(want.nodes_online));
            check_field("charger_present", 32'(got.charger_present),
                        32'(want.charger_present));
            check_field("new_node", 32'(got.new_node), 32'(want.new_node));
            check_field("node_slot", 32'(got.node_slot), 32'(want.node_slot));
            check_field("limits_seen", 32'(got.limits_seen), 32'(want.limits_seen));
            check_field("send_keepalive", 32'(got.send_keepalive),
                        32'(want.send_keepalive));
            check_field("send_poll", 32'(got.send_poll), 32'(want.send_poll));
            check_field("bus_silent", 32'(got.bus_silent), 32'(want.bus_silent));
            n_checked++;
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    cndm_item_if   item_bus ();
    cndm_result_if result_bus ();

    discovery_scoreboard sb = new();
    bit idle_on;
    int live_items;
    int cycle_count;

    can_node_discovery_monitor u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_bus),
        .result_out (result_bus),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Drop the run if it hangs
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("== FAIL ==");
        $finish;
    end

    // Result side: check each accepted transaction, stall in random bursts
    initial
    begin : result_sink
        int stall_left;
        discovery_result_t got;
        stall_left = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_bus.valid && result_bus.ready)
            begin
                got = '{phase_t'(result_bus.phase), result_bus.nodes_online,
                        result_bus.charger_present, result_bus.new_node,
                        result_bus.node_slot, result_bus.limits_seen,
                        result_bus.send_keepalive, result_bus.send_poll,
                        result_bus.bus_silent};
                sb.check_result(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 12);
            end
        end
    end

    // Offer one item and hold it until the transaction completes
    task automatic send_item(op_t op, logic [ID_W-1:0] id, logic [7:0] byte1,
                             logic [4:0] idx);
        if (op != OP_TICK || sb.phase != PH_IDLE)
            live_items++;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            item_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        item_bus.valid         <= 1'b1;
        item_bus.opcode        <= op;
        item_bus.frame_id      <= id;
        item_bus.payload_byte1 <= byte1;
        item_bus.entry_index   <= idx;
        @(posedge clk);
        while (!(item_bus.valid && item_bus.ready))
            @(posedge clk);
        sb.note_item(op, id, byte1, idx);
    endtask

    // Wait until the block has nothing left in flight
    task automatic drain();
        item_bus.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] reg_idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(reg_idx, value);
    endtask

    task automatic program_regs(logic [4:0] exp_cnt, logic [4:0] wl_cnt,
                                logic [31:0] chg_id, logic [15:0] window,
                                logic [15:0] poll, logic [15:0] ka, logic [15:0] silence);
        apb_write(REG_EXPECTED, 32'(exp_cnt));
        apb_write(REG_WL_SIZE, 32'(wl_cnt));
        apb_write(REG_CHARGER_ID, chg_id);
        apb_write(REG_WINDOW, 32'(window));
        apb_write(REG_POLL, 32'(poll));
        apb_write(REG_KEEPALIVE, 32'(ka));
        apb_write(REG_SILENCE, 32'(silence));
    endtask

    function automatic logic [15:0] pick_interval();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 16'd0;
        else if (r == 1)
            return 16'hFFFF;
        else if (r == 2)
            return 16'd1;
        return 16'($urandom_range(1, 15));
    endfunction

    initial
    begin : stimulus
        int i;
        int k;
        int r;
        int body_len;
        int frame_pct;
        int target;
        bit noise;
        logic [4:0]  exp_cnt;
        logic [4:0]  wl_cnt;
        logic [31:0] chg_id;
        logic [15:0] window;
        logic [ID_W-1:0] id;
        logic [7:0] byte1;

        rst_n                  <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        item_bus.valid         <= 1'b0;
        item_bus.opcode        <= OP_FRAME;
        item_bus.frame_id      <= '0;
        item_bus.payload_byte1 <= '0;
        item_bus.entry_index   <= '0;
        idle_on    = 1'b1;
        live_items = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole whitelist so no search ever reads an unwritten entry
        for (i = 0; i < WHITELIST_DEPTH; i++)
        begin
            if (i == 0)
                id = 32'h0;
            else if (i == WHITELIST_DEPTH - 1)
                id = 32'hFFFF_FFFF;
            else
                id = $urandom;
            send_item(OP_WL_WRITE, id, 8'($urandom_range(0, 255)), 5'(i));
        end

        // Idle phase: tick ignored, frame only moves the silence deadline
        send_item(OP_TICK, $urandom, 8'hFF, 5'd31);
        send_item(OP_FRAME, $urandom, 8'd0, 5'd0);

        // Short session closing into failure; charger id shadows a whitelist entry
        drain();
        program_regs(5'd2, 5'd31, sb.allowed_ids[5], 16'd6, 16'd1, 16'hFFFF, 16'd2);
        send_item(OP_START, '0, '0, '0);
        send_item(OP_FRAME, sb.allowed_ids[0], LIMITS_CODE, '0);
        send_item(OP_FRAME, sb.allowed_ids[31], 8'd0, '0);
        send_item(OP_FRAME, sb.allowed_ids[0], LIMITS_CODE, '0);
        send_item(OP_FRAME, sb.allowed_ids[5], LIMITS_CODE, '0);
        send_item(OP_FRAME, 32'h1234_5678, 8'hFF, '0);
        for (i = 0; i < 8; i++)
            send_item(OP_TICK, '0, '0, '0);
        send_item(OP_FRAME, sb.allowed_ids[1], LIMITS_CODE, '0);

        // Fill the online table until it overflows into failure
        drain();
        program_regs(5'd16, 5'd31, 32'h0, 16'd40, 16'd3, 16'd2, 16'hFFFF);
        send_item(OP_START, '0, '0, '0);
        for (i = 1; i <= MAX_NODES; i++)
            send_item(OP_FRAME, sb.allowed_ids[i], (i == MAX_NODES) ? LIMITS_CODE : 8'd0, '0);
        send_item(OP_FRAME, sb.allowed_ids[MAX_NODES + 1], LIMITS_CODE, '0);
        send_item(OP_TICK, '0, '0, '0);

        // Zero intervals repeat every tick; empty whitelist, nothing expected
        drain();
        program_regs(5'd0, 5'd0, 32'hFFFF_FFFF, 16'd1, 16'd0, 16'd0, 16'd0);
        send_item(OP_START, '0, '0, '0);
        send_item(OP_FRAME, 32'hFFFF_FFFF, 8'd0, '0);
        for (i = 0; i < 3; i++)
            send_item(OP_TICK, '0, '0, '0);

        // Random sessions: new settings, usually a start, mixed traffic, then in most sessions ticks to close
        target = live_items + RANDOM_ITEMS;
        while (live_items < target)
        begin
            drain();
            idle_on = (live_items < target - QUIET_TAIL) && ($urandom_range(0, 9) >= 3);

            r = $urandom_range(0, 9);
            wl_cnt = (r == 0) ? 5'd0 : (r <= 3) ? 5'd31 : 5'($urandom_range(1, 30));
            r = $urandom_range(0, 9);
            exp_cnt = (r == 0) ? 5'd0 : (r == 1) ? 5'd16 : 5'($urandom_range(1, 8));
            r = $urandom_range(0, 9);
            if (r == 0)
                chg_id = 32'h0;
            else if (r == 1)
                chg_id = 32'hFFFF_FFFF;
            else if (r <= 3)
                chg_id = sb.allowed_ids[$urandom_range(0, WHITELIST_DEPTH - 1)];
            else
                chg_id = $urandom;
            r = $urandom_range(0, 19);
            window = (r == 0) ? 16'hFFFF : (r == 1) ? 16'd1 : 16'($urandom_range(2, 25));
            program_regs(exp_cnt, wl_cnt, chg_id, window, pick_interval(), pick_interval(),
                         pick_interval());

            noise     = ($urandom_range(0, 9) == 0);
            frame_pct = ($urandom_range(0, 3) == 0) ? 85 : 50;
            body_len  = $urandom_range(8, 70);
            if ($urandom_range(0, 9) != 0)
                send_item(OP_START, $urandom, 8'($urandom_range(0, 255)),
                          5'($urandom_range(0, 31)));

            for (k = 0; k < body_len; k++)
            begin
                r = $urandom_range(0, 99);
                byte1 = ($urandom_range(0, 3) == 0) ? LIMITS_CODE : 8'($urandom_range(0, 255));
                if (noise)
                begin
                    send_item(op_t'($urandom_range(0, 3)), $urandom, byte1,
                              5'($urandom_range(0, 31)));
                end
                else if (r < frame_pct)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 65 && sb.wl_size != 0)
                        id = sb.allowed_ids[$urandom_range(0, int'(sb.wl_size) - 1)];
                    else if (r < 77)
                        id = sb.charger_id;
                    else
                        id = $urandom;
                    send_item(OP_FRAME, id, byte1, 5'($urandom_range(0, 31)));
                end
                else if (r < 92)
                begin
                    send_item(OP_TICK, $urandom, byte1, 5'($urandom_range(0, 31)));
                end
                else if (r < 97)
                begin
                    // Rewrite a slot, often duplicating another entry
                    if ($urandom_range(0, 1) == 0)
                        id = $urandom;
                    else
                        id = sb.allowed_ids[$urandom_range(0, WHITELIST_DEPTH - 1)];
                    send_item(OP_WL_WRITE, id, byte1, 5'($urandom_range(0, 31)));
                end
                else
                begin
                    send_item(OP_START, $urandom, byte1, 5'($urandom_range(0, 31)));
                end
            end

            // Tick the window shut in most sessions
            if ($urandom_range(0, 9) < 6)
            begin
                for (k = 0; k < 30 && sb.phase == PH_DISC; k++)
                    send_item(OP_TICK, $urandom, 8'($urandom_range(0, 255)),
                              5'($urandom_range(0, 31)));
            end
        end

        // Let the last results come back, then a quiet margin
        item_bus.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Run covered %0d items and %0d checked results; %0d nodes added, %0d limit frames.",
                 live_items, sb.n_checked, sb.n_added, sb.n_limits);
        $display("Windows closed: %0d charging, %0d failed; table overflowed %0d times; %0d mismatches.",
                 sb.n_charging, sb.n_failed_close, sb.n_full, sb.errors);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
src/cndm_pkg.sv
src/cndm_if.sv
src/cndm_regs.sv
src/cndm_ctrl.sv
src/cndm_dp.sv
src/can_node_discovery_monitor.sv
tb/sv/can_node_discovery_monitor_tb.sv
